// File: rtl/core/rxs_pkg.sv
package rxs_pkg;

  // Default batch capacity
  localparam int MAX_RECORDS_DEF = 64;

  // Word field widths
  localparam int KEY_W = 32;
  localparam int TAG_W = 10;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Source of the store write data
  typedef enum logic {
    WSEL_INPUT,
    WSEL_HELD
  } wsel_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_HELD,
    ST_CMP,
    ST_WB_I,
    ST_EM_RD,
    ST_EM_WAIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  wr_en;
    wsel_t wr_sel;
    logic  rd_en;
    logic  held_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_of_order;
  } status_t;

endpackage

// File: rtl/core/rxs_if.sv
// Input channel: one record per word
interface rxs_in_if;
  import rxs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] salary_cents;
  logic [TAG_W-1:0] record_tag;
  logic             last_record;

  modport source (output valid, output salary_cents, output record_tag,
                  output last_record, input ready);
  modport sink   (input valid, input salary_cents, input record_tag,
                  input last_record, output ready);
endinterface

// Result channel: one sorted record per word
interface rxs_out_if;
  import rxs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             final_result;
  logic             dropped;

  modport source (output valid, output sorted_key, output sorted_tag,
                  output final_result, output dropped, input ready);
  modport sink   (input valid, input sorted_key, input sorted_tag,
                  input final_result, input dropped, output ready);
endinterface

// File: rtl/core/rxs_datapath.sv
module rxs_datapath #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
  localparam int AW = $clog2(MAX_RECORDS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic [rxs_pkg::KEY_W-1:0] in_key,
  input  logic [rxs_pkg::TAG_W-1:0] in_tag,
  input  rxs_pkg::cmd_t           cmd,
  input  logic [AW-1:0]           wr_addr,
  input  logic [AW-1:0]           rd_addr,
  output rxs_pkg::status_t        status,
  output logic [rxs_pkg::KEY_W-1:0] out_key,
  output logic [rxs_pkg::TAG_W-1:0] out_tag
);
  import rxs_pkg::*;

  rec_t store_r [MAX_RECORDS];
  rec_t rdata_r;
  rec_t held_r;
  rec_t wdata;
  logic desc_r;

  // Sort direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_we) begin
      desc_r <= cfg_wdata;
    end
  end

  // Write data select
  always_comb begin
    case (cmd.wr_sel)
      WSEL_INPUT: wdata = '{key: in_key, tag: in_tag};
      WSEL_HELD:  wdata = held_r;
      default:    wdata = held_r;
    endcase
  end

  // Record store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_r[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= store_r[rd_addr];
    end
  end

  // Held record at outer position i
  always_ff @(posedge clk) begin
    if (cmd.held_load) begin
      held_r <= rdata_r;
    end
  end

  // held is entry i, rdata is entry j
  assign status.out_of_order = desc_r ? (held_r.key < rdata_r.key)
                                      : (held_r.key > rdata_r.key);

  assign out_key = rdata_r.key;
  assign out_tag = rdata_r.tag;

endmodule

// File: rtl/core/rxs_controller.sv
module rxs_controller #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
  localparam int AW = $clog2(MAX_RECORDS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_final,
  output logic             out_dropped,
  input  rxs_pkg::status_t status,
  output rxs_pkg::cmd_t    cmd,
  output logic [AW-1:0]    wr_addr,
  output logic [AW-1:0]    rd_addr
);
  import rxs_pkg::*;

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] last_pos;
  logic          j_last;
  logic          i_last;
  logic          k_last;

  assign in_acc    = (state_r == ST_LOAD) && in_valid;
  assign has_room  = count_r < MAX_C;
  assign count_inc = has_room ? count_r + ONE_C : count_r;
  assign last_pos  = count_r - ONE_C;
  assign j_last    = CW'(j_r) == last_pos;
  assign i_last    = (CW'(i_r) + ONE_C) == last_pos;
  assign k_last    = CW'(k_r) == last_pos;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = (count_inc < TWO_C) ? ST_EM_RD : ST_RD_I;
        end
      end
      ST_RD_I:    state_nxt = ST_LD_HELD;
      ST_LD_HELD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (j_last) begin
          state_nxt = ST_WB_I;
        end
      end
      ST_WB_I:    state_nxt = i_last ? ST_EM_RD : ST_RD_I;
      ST_EM_RD:   state_nxt = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (out_ready) begin
          state_nxt = k_last ? ST_LOAD : ST_EM_RD;
        end
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // Counters: fill count, outer i, inner j, emit k
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          count_nxt = count_inc;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt = '0;
            k_nxt = '0;
          end
        end
      end
      ST_LD_HELD: j_nxt = i_r + AW'(1);
      ST_CMP:     j_nxt = j_r + AW'(1);
      ST_WB_I:    i_nxt = i_r + AW'(1);
      ST_EM_WAIT: begin
        if (out_ready) begin
          if (k_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd       = '{wr_en: 1'b0, wr_sel: WSEL_HELD, rd_en: 1'b0, held_load: 1'b0};
    wr_addr   = i_r;
    rd_addr   = i_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.wr_en  = in_valid && has_room;
        cmd.wr_sel = WSEL_INPUT;
        wr_addr    = count_r[AW-1:0];
      end
      ST_RD_I: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i_r;
      end
      ST_LD_HELD: begin
        cmd.held_load = 1'b1;
        cmd.rd_en     = 1'b1;
        rd_addr       = i_r + AW'(1);
      end
      ST_CMP: begin
        // swap: old held goes to j, entry j becomes held
        cmd.rd_en     = 1'b1;
        rd_addr       = j_r + AW'(1);
        cmd.wr_en     = status.out_of_order;
        cmd.held_load = status.out_of_order;
        wr_addr       = j_r;
      end
      ST_WB_I: begin
        cmd.wr_en = 1'b1;
        wr_addr   = i_r;
      end
      ST_EM_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = k_r;
      end
      ST_EM_WAIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_final   = k_last;
  assign out_dropped = ovf_r;

endmodule

// File: rtl/core/record_exchange_sort_top.sv
// Load: one record per cycle while in the load state.
// Sort: one compare per cycle on the single read port of the record store.
// Emit: each result word is read from the store, then held until the sink takes it.
// Reset (rst_n low, synchronous) clears the sequencer, fill count, drop flag
// and sort direction; the record store is not cleared.
module record_exchange_sort_top #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rxs_in_if.sink      in_bus,
  rxs_out_if.source   out_bus
);
  import rxs_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  rxs_controller #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_last     (in_bus.last_record),
    .in_ready    (in_bus.ready),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_final   (out_bus.final_result),
    .out_dropped (out_bus.dropped),
    .status      (status),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr)
  );

  rxs_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_key    (in_bus.salary_cents),
    .in_tag    (in_bus.record_tag),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .status    (status),
    .out_key   (out_bus.sorted_key),
    .out_tag   (out_bus.sorted_tag)
  );

endmodule

// File: rtl/core/rxs_checker.sv
module rxs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rxs_pkg::KEY_W-1:0] sorted_key,
  input logic [rxs_pkg::TAG_W-1:0] sorted_tag,
  input logic                      final_result
);
  import rxs_pkg::*;

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sorted_key) && $stable(sorted_tag))
    else $error("result payload changed while stalled");

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during emission");

  // After the final word the block goes back to loading
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && final_result |=> !out_valid && in_ready)
    else $error("emission continued after final word");

endmodule

bind record_exchange_sort_top rxs_checker u_rxs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .sorted_key   (out_bus.sorted_key),
  .sorted_tag   (out_bus.sorted_tag),
  .final_result (out_bus.final_result)
);
